[hw/rtl/time_slot_bitmap_core_assert.svh]
// Assertion macros for the time slot bitmap core.
// Included by the top level; uses its clk and rst_n signals.
`ifndef TIME_SLOT_BITMAP_CORE_ASSERT_SVH
`define TIME_SLOT_BITMAP_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TSB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/tsb_pkg.sv]
// Shared types and constants for the time slot bitmap core.
// No dependencies; used by the core and its instances.
package tsb_pkg;

  localparam int SLOTS_DEF     = 1440;
  localparam int WORD_BITS_DEF = 32;

  localparam int OPCODE_W = 3;
  localparam int SLOT_W   = 11;
  localparam int STATUS_W = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_SET   = 3'd0,
    OP_CLEAR = 3'd1,
    OP_FILL  = 3'd2,
    OP_EMPTY = 3'd3,
    OP_QUERY = 3'd4
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_BAD_RANGE    = 2'd1,
    ST_OUT_OF_RANGE = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_SWEEP = 1'b1
  } state_t;

endpackage

[hw/rtl/tsb_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module tsb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 45,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/time_slot_bitmap_core.sv]
// Time slot bitmap core: one bit per slot, held in a word-wide RAM.
// Depends on tsb_pkg, tsb_ram and time_slot_bitmap_core_assert.svh.
//
// An item is taken when start is high and busy is low; its single result
// shows on the out_ ports for one cycle with out_strobe high, and the
// receiver cannot hold it off. Empty, unused opcodes, and any set, clear or
// query that is rejected with an error status finish without a sweep: the
// result strobes in the cycle after the item is taken. A set or clear with a
// good range, fill, and a query of a slot below the end sweep every RAM word
// with one read-modify-write per cycle; such an item's result strobes once the
// last word has been written back, and the next item can be taken at the edge
// that ends the strobe. The bitmap reads as empty right after reset; a per-word
// valid bit stands in for a clearing pass.
module time_slot_bitmap_core #(
  parameter int SLOTS     = tsb_pkg::SLOTS_DEF,
  parameter int WORD_BITS = tsb_pkg::WORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [tsb_pkg::OPCODE_W-1:0]  in_opcode,
  input  logic [tsb_pkg::SLOT_W-1:0]    in_slot_first,
  input  logic [tsb_pkg::SLOT_W-1:0]    in_slot_last,
  output logic                          out_strobe,
  output logic [tsb_pkg::STATUS_W-1:0]  out_status,
  output logic                          out_slot_filled
);

  localparam int SLOT_DEPTH = (SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW         = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
  localparam int CW         = $clog2(SLOT_DEPTH + 1);
  localparam int SPAN_W     = $clog2(SLOT_DEPTH * WORD_BITS + WORD_BITS);
  localparam int SLOT_W     = tsb_pkg::SLOT_W;
  localparam int CMP_W      = (SPAN_W > SLOT_W) ? SPAN_W : SLOT_W;

  tsb_pkg::state_t  state_r, state_nxt;
  tsb_pkg::opcode_t op_r, op_nxt;
  logic [SLOT_W-1:0]     lo_r, lo_nxt;
  logic [SLOT_W-1:0]     hi_r, hi_nxt;
  logic [CW-1:0]         rd_cnt_r, rd_cnt_nxt;
  logic                  pend_r, pend_nxt;
  logic [AW-1:0]         wr_word_r, wr_word_nxt;
  logic                  rd_ok_r, rd_ok_nxt;
  logic [SPAN_W-1:0]     base_r, base_nxt;
  logic                  hit_r, hit_nxt;
  logic [SLOT_DEPTH-1:0] valid_r, valid_nxt;

  logic                  strobe_r, strobe_nxt;
  logic [tsb_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic                  filled_r, filled_nxt;

  logic                  mem_re, mem_we;
  logic [AW-1:0]         mem_raddr;
  logic [WORD_BITS-1:0]  mem_rdata, mem_wdata;
  logic [WORD_BITS-1:0]  old_word, mask;
  logic [SLOT_W-1:0]     last_eff;
  logic                  accept;

  tsb_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (SLOT_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_word_r),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign busy   = (state_r != tsb_pkg::S_IDLE);
  assign accept = start && !busy;

  // Bits of the word in the write stage whose slot lies in [lo, hi].
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      mask[b] = (CMP_W'(base_r) + CMP_W'(b) >= CMP_W'(lo_r)) &&
                (CMP_W'(base_r) + CMP_W'(b) <= CMP_W'(hi_r));
    end
  end

  assign old_word  = rd_ok_r ? mem_rdata : '0;
  assign mem_wdata = (op_r == tsb_pkg::OP_CLEAR) ? (old_word & ~mask) : (old_word | mask);
  assign last_eff  = (in_slot_last == '0) ? in_slot_first : in_slot_last;
  assign mem_raddr = rd_cnt_r[AW-1:0];

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    rd_cnt_nxt  = rd_cnt_r;
    pend_nxt    = 1'b0;
    wr_word_nxt = wr_word_r;
    rd_ok_nxt   = rd_ok_r;
    base_nxt    = base_r;
    hit_nxt     = hit_r;
    valid_nxt   = valid_r;
    strobe_nxt  = 1'b0;
    status_nxt  = status_r;
    filled_nxt  = filled_r;
    mem_re      = 1'b0;
    mem_we      = 1'b0;

    case (state_r)
      tsb_pkg::S_IDLE: begin
        if (accept) begin
          op_nxt     = tsb_pkg::opcode_t'(in_opcode);
          rd_cnt_nxt = '0;
          base_nxt   = '0;
          hit_nxt    = 1'b0;
          status_nxt = tsb_pkg::ST_OK;
          filled_nxt = 1'b0;
          case (in_opcode)
            tsb_pkg::OP_SET, tsb_pkg::OP_CLEAR: begin
              lo_nxt = in_slot_first;
              hi_nxt = last_eff;
              if (in_slot_first > last_eff) begin
                status_nxt = tsb_pkg::ST_BAD_RANGE;
                strobe_nxt = 1'b1;
              end else if (32'(last_eff) >= 32'(SLOTS)) begin
                status_nxt = tsb_pkg::ST_OUT_OF_RANGE;
                strobe_nxt = 1'b1;
              end else begin
                state_nxt = tsb_pkg::S_SWEEP;
              end
            end
            tsb_pkg::OP_FILL: begin
              lo_nxt    = '0;
              hi_nxt    = SLOT_W'(SLOTS - 1);
              state_nxt = tsb_pkg::S_SWEEP;
            end
            tsb_pkg::OP_EMPTY: begin
              valid_nxt  = '0;
              strobe_nxt = 1'b1;
            end
            tsb_pkg::OP_QUERY: begin
              lo_nxt = in_slot_first;
              hi_nxt = in_slot_first;
              if (32'(in_slot_first) >= 32'(SLOTS)) begin
                status_nxt = tsb_pkg::ST_OUT_OF_RANGE;
                strobe_nxt = 1'b1;
              end else begin
                state_nxt = tsb_pkg::S_SWEEP;
              end
            end
            default: begin
              strobe_nxt = 1'b1;
            end
          endcase
        end
      end
      tsb_pkg::S_SWEEP: begin
        // Read word k while word k-1 is modified and written back.
        if (rd_cnt_r < CW'(SLOT_DEPTH)) begin
          mem_re      = 1'b1;
          rd_cnt_nxt  = rd_cnt_r + CW'(1);
          pend_nxt    = 1'b1;
          wr_word_nxt = mem_raddr;
          rd_ok_nxt   = valid_r[mem_raddr];
        end
        if (pend_r) begin
          base_nxt = base_r + SPAN_W'(WORD_BITS);
          hit_nxt  = hit_r | (|(old_word & mask));
          if (op_r != tsb_pkg::OP_QUERY) begin
            mem_we             = 1'b1;
            valid_nxt[wr_word_r] = 1'b1;
          end
          if (wr_word_r == AW'(SLOT_DEPTH - 1)) begin
            state_nxt  = tsb_pkg::S_IDLE;
            strobe_nxt = 1'b1;
            filled_nxt = (op_r == tsb_pkg::OP_QUERY) && (hit_r | (|(old_word & mask)));
          end
        end
      end
      default: begin
        state_nxt = tsb_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= tsb_pkg::S_IDLE;
      pend_r   <= 1'b0;
      strobe_r <= 1'b0;
      valid_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      pend_r   <= pend_nxt;
      strobe_r <= strobe_nxt;
      valid_r  <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    rd_cnt_r  <= rd_cnt_nxt;
    wr_word_r <= wr_word_nxt;
    rd_ok_r   <= rd_ok_nxt;
    base_r    <= base_nxt;
    hit_r     <= hit_nxt;
    status_r  <= status_nxt;
    filled_r  <= filled_nxt;
  end

  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_slot_filled = filled_r;

`include "time_slot_bitmap_core_assert.svh"

  `TSB_ASSERT_NEXT(a_item_progresses, accept, out_strobe || busy,
    "accepted item neither finished nor started a sweep")
  `TSB_ASSERT_SAME(a_no_write_idle, state_r == tsb_pkg::S_IDLE, !mem_we,
    "bitmap RAM written while idle")
  `TSB_ASSERT_SAME(a_filled_only_ok, out_strobe && (out_status != tsb_pkg::ST_OK),
    !out_slot_filled, "slot reported filled on an error status")

endmodule

[tb/time_slot_bitmap_core_tb.sv]
// Testbench for time_slot_bitmap_core: directed and random slot commands,
// each result checked against a behavioral copy of the slot bitmap.
// Depends on tsb_pkg and the core's RTL; needs no files or arguments.
`timescale 1ns / 100ps

module time_slot_bitmap_core_tb;
  import tsb_pkg::*;

  localparam int SLOT_COUNT = SLOTS_DEF;
  localparam int WORD_COUNT = (SLOTS_DEF + WORD_BITS_DEF - 1) / WORD_BITS_DEF;
  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_PER_PHASE = 670;
  localparam logic [OPCODE_W-1:0] OP_CODE_TOP = '1;
  localparam logic [SLOT_W-1:0] SLOT_INDEX_TOP = '1;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                filled;
  } slot_reply_t;

  class slot_map_scoreboard;
    bit [SLOT_COUNT-1:0] slot_map;
    slot_reply_t replies_due[$];
    int mismatches;
    int checked;
    int status_seen[4];

    function void note_item(logic [OPCODE_W-1:0] op, logic [SLOT_W-1:0] first,
                            logic [SLOT_W-1:0] last);
      slot_reply_t reply;
      int lo;
      int hi;
      reply.status = ST_OK;
      reply.filled = 1'b0;
      lo = int'(first);
      hi = int'(last);
      case (op)
        OP_SET, OP_CLEAR: begin
          if (hi == 0) hi = lo;
          if (lo > hi) begin
            reply.status = ST_BAD_RANGE;
          end else if (hi >= SLOT_COUNT) begin
            reply.status = ST_OUT_OF_RANGE;
          end else begin
            for (int s = lo; s <= hi; s++) slot_map[s] = (op == OP_SET);
          end
        end
        OP_FILL: slot_map = '1;
        OP_EMPTY: slot_map = '0;
        OP_QUERY: begin
          if (lo >= SLOT_COUNT) reply.status = ST_OUT_OF_RANGE;
          else reply.filled = slot_map[lo];
        end
        default: ;
      endcase
      replies_due.push_back(reply);
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic filled);
      slot_reply_t want;
      if (replies_due.size() == 0) begin
        $error("result with no item outstanding: status %0d, slot_filled %0d",
               status, filled);
        mismatches++;
        return;
      end
      want = replies_due.pop_front();
      checked++;
      status_seen[status]++;
      if (status !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, status);
        mismatches++;
      end
      if (filled !== want.filled) begin
        $error("slot_filled mismatch: expected %0d, actual %0d", want.filled, filled);
        mismatches++;
      end
    endfunction

    function int pending();
      return replies_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [OPCODE_W-1:0] in_opcode = '0;
  logic [SLOT_W-1:0] in_slot_first = '0;
  logic [SLOT_W-1:0] in_slot_last = '0;
  logic out_strobe;
  logic [STATUS_W-1:0] out_status;
  logic out_slot_filled;

  slot_map_scoreboard sb = new();
  int sender_idle_pct = 15;
  int quiet_cycles = 0;
  int op_count[1 << OPCODE_W];

  time_slot_bitmap_core #(
    .SLOTS(SLOTS_DEF),
    .WORD_BITS(WORD_BITS_DEF)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_opcode(in_opcode),
    .in_slot_first(in_slot_first),
    .in_slot_last(in_slot_last),
    .out_strobe(out_strobe),
    .out_status(out_status),
    .out_slot_filled(out_slot_filled)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) sb.check_result(out_status, out_slot_filled);
      if (start && !busy) begin
        sb.note_item(in_opcode, in_slot_first, in_slot_last);
        op_count[in_opcode]++;
      end
      if (out_strobe || (start && !busy)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("time_slot_bitmap_core verification failed");
    $finish;
  end

  // Holds the item on the ports until it is taken, then maybe idles.
  task automatic issue_command(input logic [OPCODE_W-1:0] op,
                               input logic [SLOT_W-1:0] first,
                               input logic [SLOT_W-1:0] last);
    int gap;
    start <= 1'b1;
    in_opcode <= op;
    in_slot_first <= first;
    in_slot_last <= last;
    do @(posedge clk); while (busy);
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    // Occasional long gaps land in every part of a sweep.
    if (sender_idle_pct > 0 && $urandom_range(7) == 0) gap += $urandom_range(1, 60);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic random_command();
    int pick;
    logic [SLOT_W-1:0] first;
    logic [SLOT_W-1:0] last;
    int span;
    pick = $urandom_range(99);
    first = SLOT_W'($urandom_range(SLOT_COUNT - 1));
    last = SLOT_W'($urandom);
    if (pick < 45) begin
      span = ($urandom_range(9) == 0) ? $urandom_range(SLOT_COUNT - 1)
                                      : $urandom_range(40);
      case ($urandom_range(9))
        0, 1: last = '0;
        2: begin
          first = SLOT_W'($urandom);
          last = SLOT_W'($urandom);
        end
        default: last = SLOT_W'((first + span >= SLOT_COUNT) ? SLOT_COUNT - 1 : first + span);
      endcase
      issue_command((pick < 25) ? OP_SET : OP_CLEAR, first, last);
    end else if (pick < 48) begin
      issue_command(OP_FILL, SLOT_W'($urandom), SLOT_W'($urandom));
    end else if (pick < 51) begin
      issue_command(OP_EMPTY, SLOT_W'($urandom), SLOT_W'($urandom));
    end else if (pick < 88) begin
      if ($urandom_range(9) == 0) first = SLOT_W'($urandom);
      issue_command(OP_QUERY, first, last);
    end else if (pick < 92) begin
      issue_command(OPCODE_W'($urandom_range(int'(OP_QUERY) + 1, int'(OP_CODE_TOP))),
                    SLOT_W'($urandom), SLOT_W'($urandom));
    end else begin
      issue_command(OPCODE_W'($urandom), SLOT_W'($urandom), SLOT_W'($urandom));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed commands: extremes, single slots, error ordering, word edges.
    issue_command(OP_QUERY, '0, SLOT_INDEX_TOP);
    issue_command(OP_QUERY, SLOT_W'(SLOT_COUNT - 1), '0);
    issue_command(OP_SET, '0, '0);
    issue_command(OP_QUERY, '0, '0);
    issue_command(OP_SET, SLOT_W'(SLOT_COUNT - 32), SLOT_W'(SLOT_COUNT - 1));
    issue_command(OP_QUERY, SLOT_W'(SLOT_COUNT - 1), '0);
    issue_command(OP_SET, SLOT_W'(100), SLOT_W'(50));
    issue_command(OP_SET, SLOT_W'(5), SLOT_W'(SLOT_COUNT));
    issue_command(OP_CLEAR, '0, SLOT_INDEX_TOP);
    issue_command(OP_SET, SLOT_INDEX_TOP, '0);
    issue_command(OP_CLEAR, SLOT_INDEX_TOP, SLOT_W'(5));
    issue_command(OP_QUERY, SLOT_INDEX_TOP, SLOT_INDEX_TOP);
    issue_command(OP_QUERY, SLOT_W'(SLOT_COUNT), '0);
    issue_command(OP_FILL, SLOT_INDEX_TOP, SLOT_INDEX_TOP);
    issue_command(OP_QUERY, SLOT_W'(777), '0);
    issue_command(OP_CLEAR, SLOT_W'(31), SLOT_W'(32));
    issue_command(OP_QUERY, SLOT_W'(30), '0);
    issue_command(OP_QUERY, SLOT_W'(31), '0);
    issue_command(OP_QUERY, SLOT_W'(32), '0);
    issue_command(OP_CLEAR, '0, SLOT_W'(SLOT_COUNT - 1));
    issue_command(OP_QUERY, SLOT_W'(SLOT_COUNT - 1), '0);
    issue_command(OP_FILL, '0, '0);
    issue_command(OP_EMPTY, SLOT_INDEX_TOP, SLOT_INDEX_TOP);
    issue_command(OP_QUERY, '0, '0);
    issue_command(OP_CODE_TOP, SLOT_INDEX_TOP, SLOT_INDEX_TOP);

    repeat (RANDOM_PER_PHASE) random_command();
    sender_idle_pct = 57;
    repeat (RANDOM_PER_PHASE) random_command();
    sender_idle_pct = 0;
    repeat (RANDOM_PER_PHASE) random_command();
    start <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (WORD_COUNT + 4) @(posedge clk);

    $display("Sent %0d set, %0d clear, %0d fill, %0d empty, %0d query items, %0d unused",
             op_count[OP_SET], op_count[OP_CLEAR], op_count[OP_FILL], op_count[OP_EMPTY],
             op_count[OP_QUERY], op_count[5] + op_count[6] + op_count[7]);
    $display("Checked %0d results: %0d ok, %0d bad range, %0d out of range",
             sb.checked, sb.status_seen[ST_OK], sb.status_seen[ST_BAD_RANGE],
             sb.status_seen[ST_OUT_OF_RANGE]);
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.mismatches++;
    end
    if (sb.mismatches == 0) begin
      $display("time_slot_bitmap_core verification clean");
    end else begin
      $display("time_slot_bitmap_core verification failed");
    end
    $finish;
  end

endmodule
